[hdl/assert_macros.svh]
// Assertion helpers used by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that cond holds whenever the strobe is high.
`define ASSERT_WHEN(label, clk, rst_n, strobe, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, (strobe) |-> (cond), msg)

`endif

[hdl/hofit_pkg.sv]
`default_nettype none

package hofit_pkg;

    localparam int BASE_PAGE_SHIFT = 12;
    localparam int TOP_ORDER       = 9;
    localparam int ADDR_BITS       = 48;

    localparam int MIN_ORDER = 2;
    localparam int MASK_BITS = 10;
    localparam int CNT_W     = 5;
    localparam int ORD_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 5;
    // room for an aligned address plus a shifted page count
    localparam int FIT_W     = ADDR_BITS + CNT_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIT_PAGES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC_BOOST_ON  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_ON    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NODE_ON  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRESH_CUT_ON   = 3'd5;

    typedef enum logic [1:0] {
        DEC_DISABLED  = 2'd0,
        DEC_TOO_SMALL = 2'd1,
        DEC_PMD_PASS  = 2'd2,
        DEC_MASKED    = 2'd3
    } t_decision;

    typedef enum logic [1:0] {
        CLS_STACK     = 2'd0,
        CLS_EXEC_FILE = 2'd1,
        CLS_ANON      = 2'd2,
        CLS_FILE      = 2'd3
    } t_class;

    typedef struct packed {
        logic [ADDR_BITS-1:0] region_start;
        logic [ADDR_BITS-1:0] region_end;
        logic                 grows_down;
        logic                 executable;
        logic                 file_backed;
        logic                 anonymous;
        logic                 ever_faulted;
        logic [MASK_BITS-1:0] allowed_mask;
        logic [MASK_BITS-1:0] free_any_mask;
        logic [MASK_BITS-1:0] free_local_mask;
    } t_req;

    typedef struct packed {
        logic [MASK_BITS-1:0] orders_out;
        logic [ORD_W-1:0]     chosen_order;
        t_decision            decision;
        t_class               region_class;
        logic                 pressure_lowered;
        logic                 node_downgraded;
        logic                 fresh_cut;
        logic                 all_suppressed;
    } t_res;

    // fit results: one aligned order-2 page, and min_fit_pages pages per order
    typedef struct packed {
        logic                         one;
        logic [TOP_ORDER:MIN_ORDER]   cnt;
    } t_fit;

    typedef struct packed {
        logic             found;
        logic [ORD_W-1:0] ord;
    } t_pick;

    // orders past the mask width count as not free
    function automatic logic bit_at(input logic [MASK_BITS-1:0] mask,
                                    input logic [ORD_W-1:0] ord);
        logic b;
        b = 1'b0;
        if (ord < ORD_W'(MASK_BITS))
            b = mask[ord];
        return b;
    endfunction

    // highest order in [MIN_ORDER, lim) whose mask bit is set
    function automatic t_pick highest_below(input logic [MASK_BITS-1:0] mask,
                                            input logic [ORD_W-1:0] lim);
        t_pick p;
        p.found = 1'b0;
        p.ord   = ORD_W'(MIN_ORDER);
        for (int o = MIN_ORDER; o <= TOP_ORDER; o++) begin
            if (ORD_W'(o) < lim && bit_at(mask, ORD_W'(o))) begin
                p.found = 1'b1;
                p.ord   = ORD_W'(o);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[hdl/hofit_fit.sv]
`default_nettype none

module hofit_fit (
    input  wire logic [hofit_pkg::ADDR_BITS-1:0] i_start,
    input  wire logic [hofit_pkg::ADDR_BITS-1:0] i_end,
    input  wire logic [hofit_pkg::CNT_W-1:0]     i_count,
    output hofit_pkg::t_fit                      o_fit
);
    import hofit_pkg::*;

    logic [FIT_W-1:0] start_x;
    logic [FIT_W-1:0] end_x;
    logic [FIT_W-1:0] first2;
    logic [FIT_W-1:0] size2;

    assign start_x = FIT_W'(i_start);
    assign end_x   = FIT_W'(i_end);

    // one aligned order-2 page must fit before anything else
    localparam int SH2 = BASE_PAGE_SHIFT + MIN_ORDER;
    localparam logic [FIT_W-1:0] LOW2 = (FIT_W'(1) << SH2) - FIT_W'(1);

    assign first2   = (start_x + LOW2) & ~LOW2;
    assign size2    = LOW2 + FIT_W'(1);
    assign o_fit.one = (first2 < end_x) && ((end_x - first2) >= size2);

    // one comparator per order, all side by side
    for (genvar o = MIN_ORDER; o <= TOP_ORDER; o++) begin : g_ord
        localparam int SH = BASE_PAGE_SHIFT + o;
        localparam logic [FIT_W-1:0] LOW = (FIT_W'(1) << SH) - FIT_W'(1);
        logic [FIT_W-1:0] first;
        logic [FIT_W-1:0] need;

        assign first = (start_x + LOW) & ~LOW;
        assign need  = FIT_W'(i_count) << SH;
        assign o_fit.cnt[o] = (first < end_x) && ((end_x - first) >= need);
    end

endmodule

`default_nettype wire

[hdl/hugepage_order_fit_filter.sv]
// Huge-page order fit filter. Raise i_start with a request word on i_req
// whenever o_busy is low; o_busy is low at all times outside reset, so a
// request can be issued on every clock. Each request gives exactly one result
// word on o_res, flagged by o_done for a single cycle once the request has
// passed the input register and then the result register; results come out
// in request order and the receiver has no way to hold them, so it must
// take each word in the cycle o_done is high.
// Throughput is one request per clock: the eight per-order alignment
// comparators run side by side, followed by a short chain of priority picks
// over the ten-bit free masks. Write configuration through i_cfg_we /
// i_cfg_idx / i_cfg_wdata only while no request is in flight; reset loads
// the defaults (filter on, two pages to fit, all adjustments on).
`default_nettype none
`include "assert_macros.svh"

module hugepage_order_fit_filter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire hofit_pkg::t_req               i_req,
    output logic                               o_done,
    output hofit_pkg::t_res                    o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [hofit_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [hofit_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import hofit_pkg::*;

    // configuration registers
    logic             r_filter_en;
    logic [CNT_W-1:0] r_min_pages;
    logic             r_boost_on;
    logic             r_press_on;
    logic             r_local_on;
    logic             r_fresh_on;

    // input stage
    logic r_in_vld;
    t_req r_in;

    // result stage
    logic r_done;
    t_res r_res;
    t_res n_res;

    t_fit fit;

    // only reset holds off requests
    assign o_busy = ~i_rst_n;

    // configuration writes: no wait state, unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= 1'b1;
            r_min_pages <= CNT_W'(2);
            r_boost_on  <= 1'b1;
            r_press_on  <= 1'b1;
            r_local_on  <= 1'b1;
            r_fresh_on  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FILTER_ENABLE: r_filter_en <= i_cfg_wdata[0];
                CFG_MIN_FIT_PAGES: r_min_pages <= i_cfg_wdata[CNT_W-1:0];
                CFG_EXEC_BOOST_ON: r_boost_on  <= i_cfg_wdata[0];
                CFG_PRESSURE_ON:   r_press_on  <= i_cfg_wdata[0];
                CFG_LOCAL_NODE_ON: r_local_on  <= i_cfg_wdata[0];
                CFG_FRESH_CUT_ON:  r_fresh_on  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // capture the request word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start && !o_busy;
        end
        if (i_start && !o_busy) begin
            r_in <= i_req;
        end
    end

    // alignment fit for every order at once
    hofit_fit u_fit (
        .i_start (r_in.region_start),
        .i_end   (r_in.region_end),
        .i_count (r_min_pages),
        .o_fit   (fit)
    );

    always_comb begin
        t_class           cls;
        logic [ORD_W-1:0] ord;
        logic             got;
        t_pick            pick;
        logic [MASK_BITS-1:0] keep;

        // classify: stack, then exec file, then anonymous, else plain file
        if (r_in.grows_down)
            cls = CLS_STACK;
        else if (r_in.executable && r_in.file_backed)
            cls = CLS_EXEC_FILE;
        else if (r_in.anonymous)
            cls = CLS_ANON;
        else
            cls = CLS_FILE;

        pick = '0;
        keep = '0;

        // largest order where the required number of pages fits; stacks take order 2
        got = 1'b0;
        ord = ORD_W'(0);
        if (r_in.grows_down) begin
            got = 1'b1;
            ord = ORD_W'(MIN_ORDER);
        end else begin
            for (int o = MIN_ORDER; o <= TOP_ORDER; o++) begin
                if (fit.cnt[o]) begin
                    got = 1'b1;
                    ord = ORD_W'(o);
                end
            end
        end

        n_res                     = '0;
        n_res.region_class        = cls;
        n_res.decision            = DEC_TOO_SMALL;

        if (!r_filter_en) begin
            n_res.orders_out = r_in.allowed_mask;
            n_res.decision   = DEC_DISABLED;
        end else if (fit.one && got) begin
            if (!r_in.grows_down) begin
                // exec boost
                if (cls == CLS_EXEC_FILE && r_boost_on && ord < ORD_W'(TOP_ORDER))
                    ord = ord + ORD_W'(1);
                // pressure: drop to highest order with free blocks, floor at 2
                if (r_press_on && !bit_at(r_in.free_any_mask, ord)) begin
                    pick = highest_below(r_in.free_any_mask, ord);
                    if (pick.ord < ord) begin
                        ord = pick.ord;
                        n_res.pressure_lowered = 1'b1;
                    end
                end
                // local node: drop only when a lower free order exists
                if (r_local_on && !bit_at(r_in.free_local_mask, ord)) begin
                    pick = highest_below(r_in.free_local_mask, ord);
                    if (pick.found) begin
                        ord = pick.ord;
                        n_res.node_downgraded = 1'b1;
                    end
                end
                // never-faulted region loses one order
                if (r_fresh_on && !r_in.ever_faulted && ord > ORD_W'(MIN_ORDER)) begin
                    ord = ord - ORD_W'(1);
                    n_res.fresh_cut = 1'b1;
                end
            end
            if (ord >= ORD_W'(TOP_ORDER)) begin
                n_res.orders_out   = r_in.allowed_mask;
                n_res.chosen_order = ord;
                n_res.decision     = DEC_PMD_PASS;
            end else begin
                for (int i = 0; i < MASK_BITS; i++)
                    keep[i] = (ORD_W'(i) <= ord);
                n_res.orders_out   = r_in.allowed_mask & keep;
                n_res.chosen_order = (n_res.orders_out != '0) ? ord : ORD_W'(0);
                n_res.decision     = DEC_MASKED;
            end
        end
        n_res.all_suppressed = (n_res.orders_out == '0);
    end

    // result register: one strobe per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // every taken request strobes a result through the input and result registers
    `ASSERT_CLK(a_done_lat, i_clk, i_rst_n, (i_start && !o_busy) |=> ##1 o_done, "result strobe missing")
    // empty flag tracks the mask
    `ASSERT_WHEN(a_empty, i_clk, i_rst_n, o_done, o_res.all_suppressed == (o_res.orders_out == '0), "empty flag mismatch")
    // disabled pass reports no order and no adjustments
    `ASSERT_WHEN(a_dis, i_clk, i_rst_n, o_done && o_res.decision == DEC_DISABLED, o_res.chosen_order == '0 && !o_res.pressure_lowered && !o_res.node_downgraded && !o_res.fresh_cut, "disabled pass carries order")
    // masked result always sits below the PMD order
    `ASSERT_WHEN(a_masked, i_clk, i_rst_n, o_done && o_res.decision == DEC_MASKED, o_res.chosen_order < ORD_W'(TOP_ORDER), "masked order at PMD size")

endmodule

`default_nettype wire
